>>> rtl/cum_pkg.sv
// Shared types, widths, register codes and the log2 fraction table
// for the classifier uncertainty measure. No dependencies.
package cum_pkg;

	// input probability format, signed Q1.16
	localparam int PROB_W         = 18;
	localparam int PROB_FRAC_BITS = 16;
	localparam int MAG_W          = PROB_W - 1;

	// row limits and accumulator widths
	localparam int MAX_CLASSES = 256;
	localparam int CNT_W       = 13;
	localparam int SUM_W       = 25;
	localparam int ACC_W       = 24;
	localparam int OUT_W       = 20;
	localparam int TOL_W       = 17;
	localparam int MODE_W      = 2;

	// entropy term datapath
	localparam int LOG_TABLE_BITS = 6;
	localparam int LOG_ROM_SIZE   = 1 << LOG_TABLE_BITS;
	localparam int LOG_FRAC_W     = 16;
	localparam int LOD_W          = 5;
	localparam int NL_W           = LOD_W + LOG_FRAC_W;
	localparam int PROD_W         = PROB_FRAC_BITS + NL_W;
	localparam int TERM_W         = PROD_W - PROB_FRAC_BITS;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 20;

	typedef logic signed [PROB_W-1:0] prob_t;
	typedef logic [MODE_W-1:0]        mode_t;
	typedef logic [CFG_IDX_W-1:0]     cfg_idx_t;
	typedef logic [OUT_W-1:0]         measure_t;

	// measure selection codes
	localparam mode_t MODE_ENTROPY = 2'd0;
	localparam mode_t MODE_MARGIN  = 2'd1;
	localparam mode_t MODE_MAXCONF = 2'd2;

	// register indexes
	localparam cfg_idx_t CFG_MEASURE_MODE = 2'd0;
	localparam cfg_idx_t CFG_REJECT_THR   = 2'd1;
	localparam cfg_idx_t CFG_SUM_TOL      = 2'd2;

	localparam logic [TOL_W-1:0] SUM_TOL_RESET = 17'd66;

	// per-row running state
	typedef struct packed {
		logic [SUM_W-1:0]  sum;
		logic [ACC_W-1:0]  acc;
		prob_t             top1;
		prob_t             top2;
		logic [CNT_W-1:0]  cnt;
		logic              bad;
	} row_t;

	localparam row_t ROW_CLEAR = '{
		sum:  '0,
		acc:  '0,
		top1: '1,
		top2: '1,
		cnt:  '0,
		bad:  1'b0
	};

	// floor(log2(1 + i/2^LOG_TABLE_BITS)) in Q16 by repeated squaring of a Q30 mantissa
	typedef logic [LOG_FRAC_W-1:0] log_rom_t [LOG_ROM_SIZE];

	function automatic log_rom_t build_log_rom();
		log_rom_t    rom;
		logic [63:0] x;
		logic [LOG_FRAC_W-1:0] l;
		for (int i = 0; i < LOG_ROM_SIZE; i++) begin
			x = 64'(LOG_ROM_SIZE + i) << (30 - LOG_TABLE_BITS);
			l = '0;
			for (int k = LOG_FRAC_W - 1; k >= 0; k--) begin
				x = (x * x) >> 30;
				if (x >= (64'd2 << 30)) begin
					l[k] = 1'b1;
					x    = x >> 1;
				end
			end
			rom[i] = l;
		end
		return rom;
	endfunction

	localparam log_rom_t LOG_ROM = build_log_rom();

endpackage

>>> rtl/cum_if.sv
// Valid/ready channel interfaces for the classifier uncertainty measure:
// probability stream, result stream and configuration writes. Uses cum_pkg.

interface cum_in_if import cum_pkg::*; ();
	logic  valid;
	logic  ready;
	prob_t prob;
	logic  row_end;

	modport source (output valid, prob, row_end, input ready);
	modport sink   (input valid, prob, row_end, output ready);
endinterface

interface cum_out_if import cum_pkg::*; ();
	logic     valid;
	logic     ready;
	logic     row_valid;
	measure_t measure_value;
	logic     rejected;

	modport source (output valid, row_valid, measure_value, rejected, input ready);
	modport sink   (input valid, row_valid, measure_value, rejected, output ready);
endinterface

interface cum_cfg_if import cum_pkg::*; ();
	logic                  valid;
	logic                  ready;
	cfg_idx_t              reg_index;
	logic [CFG_DATA_W-1:0] wdata;

	modport source (output valid, reg_index, wdata, input ready);
	modport sink   (input valid, reg_index, wdata, output ready);
endinterface

>>> rtl/classifier_uncertainty_measure.sv
// Classifier uncertainty measure: entropy, top-two margin or maximum confidence
// over a streamed row of class probabilities. Uses cum_pkg and the cum_*_if interfaces.
//
// Channels:
//   sample - one probability per transaction (signed Q1.16), row_end on the last one.
//   result - one transaction per row: row_valid, measure_value (Q4.16), rejected.
//   cfg    - register writes (measure_mode, reject_threshold, sum_tolerance);
//            always ready, a write takes effect on the next cycle. Write only when idle.
// Throughput: one probability per cycle, sustained, across row boundaries, unless the stall below drops sample.ready.
// Path: the last element of a row passes the input register, the entropy term
//   with its multiplier, the row accumulate and the result register, which
//   shows the result of the row.
// Stall: a result waiting on result.ready holds the result register; the next
//   finished row waits in stage 3, and sample.ready drops only once the row end
//   of a third row waits in stage 2 behind them, so non-final elements keep
//   flowing while a result is held.
// Reset: arst_n clears the pipeline valid bits and the row state and sets the
//   registers to entropy mode, threshold 0, sum tolerance 66.
module classifier_uncertainty_measure
	import cum_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	cum_in_if.sink    sample,
	cum_out_if.source result,
	cum_cfg_if.sink   cfg
);

	// configuration registers
	mode_t             mode_q;
	logic [OUT_W-1:0]  thr_q;
	logic [TOL_W-1:0]  tol_q;

	// stage 1: input register
	logic  v1;
	prob_t prob_s1;
	logic  end_s1;

	// stage 2: entropy term
	logic              v2;
	logic [TERM_W-1:0] term_s2;
	logic [MAG_W-1:0]  mag_s2;
	logic              neg_s2;
	logic              end_s2;

	// row state and stage 3 snapshot of a finished row
	row_t row_q;
	row_t row_nx;
	logic v3;
	row_t row_s3;

	// result register
	logic     out_valid_q;
	logic     row_valid_q;
	measure_t value_q;
	logic     rej_q;

	// flow control
	logic out_en;
	logic s3_free;
	logic s2_go;
	logic s2_free;

	assign out_en  = !out_valid_q || result.ready;
	assign s3_free = !v3 || out_en;
	assign s2_go   = v2 && (!end_s2 || s3_free);
	assign s2_free = !v2 || s2_go;

	assign sample.ready = !v1 || s2_free;
	assign cfg.ready    = 1'b1;

	assign result.valid         = out_valid_q;
	assign result.row_valid     = row_valid_q;
	assign result.measure_value = value_q;
	assign result.rejected      = rej_q;

	// hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_ENTROPY;
			thr_q  <= '0;
			tol_q  <= SUM_TOL_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.reg_index)
				CFG_MEASURE_MODE: mode_q <= cfg.wdata[MODE_W-1:0];
				CFG_REJECT_THR:   thr_q  <= cfg.wdata[OUT_W-1:0];
				CFG_SUM_TOL:      tol_q  <= cfg.wdata[TOL_W-1:0];
				default: ;
			endcase
		end
	end

	// stage 1 entropy term: leading one, table index, -log2 and product
	logic [MAG_W-1:0]                mag_s1;
	logic [LOD_W-1:0]                lead;
	logic [MAG_W+LOG_TABLE_BITS-1:0] shifted;
	logic [LOG_TABLE_BITS-1:0]       rom_idx;
	logic [LOG_FRAC_W-1:0]           rom_l;
	logic [NL_W-1:0]                 nl;
	logic [PROD_W-1:0]               prod;
	logic [TERM_W-1:0]               term;

	assign mag_s1 = prob_s1[MAG_W-1:0];

	always_comb begin
		lead = '0;
		for (int b = 0; b < MAG_W; b++) begin
			if (mag_s1[b]) lead = LOD_W'(b);
		end
	end

	assign shifted = ({{LOG_TABLE_BITS{1'b0}}, mag_s1} << LOG_TABLE_BITS) >> lead;
	assign rom_idx = shifted[LOG_TABLE_BITS-1:0];
	assign rom_l   = LOG_ROM[rom_idx];
	assign nl      = {LOD_W'(PROB_FRAC_BITS) - lead, {LOG_FRAC_W{1'b0}}}
	               - {{LOD_W{1'b0}}, rom_l};
	assign prod    = {{NL_W{1'b0}}, mag_s1[PROB_FRAC_BITS-1:0]} * {{PROB_FRAC_BITS{1'b0}}, nl};

	// drop the term at or above one, where -log2 is not positive
	assign term = (lead < LOD_W'(PROB_FRAC_BITS)) ? prod[PROD_W-1:PROB_FRAC_BITS] : '0;

	// advance stages 1 and 2
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1 <= 1'b0;
			v2 <= 1'b0;
		end else begin
			if (sample.valid && sample.ready) begin
				v1 <= 1'b1;
			end else if (s2_free) begin
				v1 <= 1'b0;
			end
			if (s2_free) begin
				v2 <= v1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			prob_s1 <= sample.prob;
			end_s1  <= sample.row_end;
		end
		if (s2_free && v1) begin
			term_s2 <= term;
			mag_s2  <= mag_s1;
			neg_s2  <= prob_s1[PROB_W-1];
			end_s2  <= end_s1;
		end
	end

	// stage 2 row update: count, saturating sum and entropy, top two
	logic [SUM_W:0] sum_w;
	logic [ACC_W:0] acc_w;
	prob_t          p_s2;

	assign p_s2 = {1'b0, mag_s2};

	always_comb begin
		row_nx = row_q;
		sum_w  = {1'b0, row_q.sum} + (SUM_W+1)'(mag_s2);
		acc_w  = {1'b0, row_q.acc} + (ACC_W+1)'(term_s2);
		if (row_q.cnt != '1) row_nx.cnt = row_q.cnt + 1'b1;
		if (neg_s2) begin
			row_nx.bad = 1'b1;
		end else begin
			row_nx.sum = sum_w[SUM_W] ? '1 : sum_w[SUM_W-1:0];
			row_nx.acc = acc_w[ACC_W] ? '1 : acc_w[ACC_W-1:0];
			if (p_s2 > row_q.top1) begin
				row_nx.top2 = row_q.top1;
				row_nx.top1 = p_s2;
			end else if (p_s2 > row_q.top2) begin
				row_nx.top2 = p_s2;
			end
		end
	end

	// hold row state; on row end hand the row to stage 3 and clear
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= ROW_CLEAR;
			v3    <= 1'b0;
		end else begin
			if (s2_go) begin
				row_q <= end_s2 ? ROW_CLEAR : row_nx;
			end
			if (s2_go && end_s2) begin
				v3 <= 1'b1;
			end else if (out_en) begin
				v3 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s2_go && end_s2) begin
			row_s3 <= row_nx;
		end
	end

	// stage 3 result: row checks, measure select, threshold test
	function automatic measure_t to_q16(logic [MAG_W-1:0] v);
		logic [MAG_W+16-1:0] w;
		w = ({16'b0, v} << 16) >> PROB_FRAC_BITS;
		return (w > (MAG_W+16)'({OUT_W{1'b1}})) ? '1 : w[OUT_W-1:0];
	endfunction

	localparam logic [SUM_W-1:0] SUM_ONE = SUM_W'(1 << PROB_FRAC_BITS);

	logic [SUM_W-1:0] diff;
	logic             ok;
	prob_t            margin;
	measure_t         value;
	logic             rej;

	assign diff   = (row_s3.sum >= SUM_ONE) ? row_s3.sum - SUM_ONE : SUM_ONE - row_s3.sum;
	assign margin = row_s3.top1 - row_s3.top2;
	assign ok     = !row_s3.bad && (diff <= SUM_W'(tol_q))
	              && (row_s3.cnt <= CNT_W'(MAX_CLASSES));

	always_comb begin
		value = '0;
		rej   = 1'b0;
		case (mode_q)
			MODE_ENTROPY: begin
				value = (row_s3.acc[ACC_W-1:OUT_W] != '0) ? '1 : row_s3.acc[OUT_W-1:0];
				rej   = value >= thr_q;
			end
			MODE_MARGIN: begin
				value = (row_s3.cnt < CNT_W'(2)) ? '0 : to_q16(margin[MAG_W-1:0]);
				rej   = value <= thr_q;
			end
			default: begin
				value = (row_s3.top1 > 0) ? to_q16(row_s3.top1[MAG_W-1:0]) : '0;
				rej   = value <= thr_q;
			end
		endcase
		if (!ok) begin
			value = '0;
			rej   = 1'b0;
		end
	end

	// hold the result until the receiver takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_en) begin
			out_valid_q <= v3;
		end
	end

	always_ff @(posedge clk) begin
		if (out_en && v3) begin
			row_valid_q <= ok;
			value_q     <= value;
			rej_q       <= rej;
		end
	end

endmodule

>>> rtl/cum_checker.sv
// Port-level checks for classifier_uncertainty_measure and the bind that
// attaches them. Uses cum_pkg.
module cum_checker
	import cum_pkg::*;
(
	input logic     clk,
	input logic     arst_n,
	input logic     in_ready,
	input logic     out_valid,
	input logic     out_ready,
	input logic     row_valid,
	input measure_t measure_value,
	input logic     rejected
);

	// hold a stalled result transaction
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(row_valid)
			&& $stable(measure_value) && $stable(rejected))
		else $error("result changed while stalled");

	// an invalid row carries no measure and no reject
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !row_valid |-> measure_value == '0 && !rejected)
		else $error("invalid row with nonzero measure or reject");

	// back-pressure on the input only comes from a blocked result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled while result side is free");

endmodule

bind classifier_uncertainty_measure cum_checker u_cum_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_ready      (sample.ready),
	.out_valid     (result.valid),
	.out_ready     (result.ready),
	.row_valid     (result.row_valid),
	.measure_value (result.measure_value),
	.rejected      (result.rejected)
);

>>> test/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for classifier_uncertainty_measure: streams probability
// rows, predicts each row result and compares it. Depends on cum_pkg and cum_*_if.
module testbench;
	import cum_pkg::*;

	localparam mode_t   MODE_UNUSED    = 2'd3;
	localparam int      SETTLE_CYCLES  = 8;
	localparam int      HOLDOFF_CYCLES = 250;
	localparam int      PHASE_ITEMS    = 40;
	localparam int      MAX_GEN_ROW    = 64;
	localparam int      REPORT_CAP     = 40;
	localparam realtime RUN_LIMIT_NS   = 4_000_000.0;

	localparam int unsigned     COUNT_SAT = (1 << CNT_W) - 1;
	localparam longint          SUM_SAT   = (longint'(1) << SUM_W) - 1;
	localparam longint unsigned ACC_SAT   = (64'd1 << ACC_W) - 1;
	localparam longint unsigned OUT_SAT   = (64'd1 << OUT_W) - 1;
	localparam int              ONE_PROB  = 1 << PROB_FRAC_BITS;

	typedef longint unsigned u64_t;

	typedef struct {
		prob_t prob;
		logic  is_end;
	} sample_item_t;

	typedef struct {
		logic     row_valid;
		measure_t measure_value;
		logic     rejected;
	} row_result_t;

	logic clk;
	logic arst_n;

	cum_in_if  sample_bus ();
	cum_out_if result_bus ();
	cum_cfg_if cfg_bus ();

	classifier_uncertainty_measure dut (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample_bus),
		.result (result_bus),
		.cfg    (cfg_bus)
	);

	// stimulus and expectations
	sample_item_t sample_queue[$];
	row_result_t  expected_rows[$];
	sample_item_t next_sample;

	int items_queued;
	int items_accepted;
	int rows_checked;
	int error_count;
	int settings_used;

	int tx_idle_pct;
	int rx_stall_pct;
	bit sender_hold;
	bit holdoff_go;
	bit rx_hold;

	// predictor copy of the registers and of the row state
	mode_t            cfg_mode;
	logic [OUT_W-1:0] cfg_thr;
	logic [TOL_W-1:0] cfg_tol;

	longint      row_sum;
	u64_t        row_entropy;
	int          row_top1;
	int          row_top2;
	int unsigned row_count;
	bit          row_bad;

	// clock
	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// floor(log2(1 + idx / 2^LOG_TABLE_BITS)) in Q16, squaring a Q30 mantissa
	function automatic u64_t log2_frac(int unsigned idx);
		u64_t m;
		u64_t l;
		m = u64_t'(LOG_ROM_SIZE + idx) << (30 - LOG_TABLE_BITS);
		l = 0;
		for (int b = LOG_FRAC_W - 1; b >= 0; b--) begin
			m = (m * m) >> 30;
			if (m >= (u64_t'(2) << 30)) begin
				l |= u64_t'(1) << b;
				m = m >> 1;
			end
		end
		return l;
	endfunction

	// -p * log2(p) in Q16 bits for one positive probability
	function automatic u64_t entropy_bits(int unsigned p);
		int          lead;
		int unsigned idx;
		longint      nl;
		lead = 0;
		while (lead < 31 && (p >> (lead + 1)) != 0)
			lead++;
		if (lead >= LOG_TABLE_BITS)
			idx = (p >> (lead - LOG_TABLE_BITS)) & (LOG_ROM_SIZE - 1);
		else
			idx = (p << (LOG_TABLE_BITS - lead)) & (LOG_ROM_SIZE - 1);
		nl = longint'(PROB_FRAC_BITS - lead) * 65536 - longint'(log2_frac(idx));
		if (nl <= 0)
			return 0;
		return u64_t'((longint'(p) * nl) >>> PROB_FRAC_BITS);
	endfunction

	// convert a probability magnitude to Q16 and clip to the output width
	function automatic u64_t rescale_q16(int v);
		u64_t r;
		r = (u64_t'(v) << 16) >> PROB_FRAC_BITS;
		return (r > OUT_SAT) ? OUT_SAT : r;
	endfunction

	function automatic void clear_row_state();
		row_sum     = 0;
		row_entropy = 0;
		row_top1    = -1;
		row_top2    = -1;
		row_count   = 0;
		row_bad     = 1'b0;
	endfunction

	// fold one accepted sample into the row; on row end, queue the expected result
	function automatic void absorb_sample(prob_t prob, logic is_end);
		int          pv;
		longint      sum_err;
		bit          ok;
		u64_t        val;
		bit          rej;
		row_result_t res;
		pv = int'(prob);
		if (row_count < COUNT_SAT)
			row_count++;
		if (pv < 0) begin
			row_bad = 1'b1;
		end else begin
			row_sum += pv;
			if (row_sum > SUM_SAT)
				row_sum = SUM_SAT;
			if (pv > 0) begin
				row_entropy += entropy_bits(pv);
				if (row_entropy > ACC_SAT)
					row_entropy = ACC_SAT;
			end
			if (pv > row_top1) begin
				row_top2 = row_top1;
				row_top1 = pv;
			end else if (pv > row_top2) begin
				row_top2 = pv;
			end
		end
		if (!is_end)
			return;
		sum_err = row_sum - longint'(ONE_PROB);
		if (sum_err < 0)
			sum_err = -sum_err;
		ok  = !row_bad && sum_err <= longint'(cfg_tol) && row_count <= MAX_CLASSES;
		val = 0;
		rej = 1'b0;
		if (ok) begin
			if (cfg_mode == MODE_ENTROPY) begin
				val = (row_entropy > OUT_SAT) ? OUT_SAT : row_entropy;
				rej = val >= cfg_thr;
			end else begin
				if (cfg_mode == MODE_MARGIN)
					val = (row_count < 2) ? 0 : rescale_q16(row_top1 - row_top2);
				else
					val = (row_top1 > 0) ? rescale_q16(row_top1) : 0;
				rej = val <= cfg_thr;
			end
		end
		res.row_valid     = ok;
		res.measure_value = val[OUT_W-1:0];
		res.rejected      = rej;
		expected_rows.push_back(res);
		clear_row_state();
	endfunction

	task automatic flag_mismatch(string msg);
		error_count++;
		if (error_count <= REPORT_CAP)
			$display("[%0t] MISMATCH: %s", $realtime, msg);
	endtask

	// compare one result transaction with the oldest expectation
	task automatic check_result();
		row_result_t want;
		if (expected_rows.size() == 0) begin
			flag_mismatch($sformatf("unexpected result valid=%0b value=%0d rej=%0b",
				result_bus.row_valid, result_bus.measure_value, result_bus.rejected));
			return;
		end
		want = expected_rows.pop_front();
		rows_checked++;
		if (result_bus.row_valid !== want.row_valid)
			flag_mismatch($sformatf("row %0d row_valid got %0b want %0b", rows_checked,
				result_bus.row_valid, want.row_valid));
		if (result_bus.measure_value !== want.measure_value)
			flag_mismatch($sformatf("row %0d measure_value got %0d want %0d", rows_checked,
				result_bus.measure_value, want.measure_value));
		if (result_bus.rejected !== want.rejected)
			flag_mismatch($sformatf("row %0d rejected got %0b want %0b", rows_checked,
				result_bus.rejected, want.rejected));
	endtask

	// sample driver: account the accepted transaction, then offer or hold
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_bus.valid   <= 1'b0;
			sample_bus.prob    <= '0;
			sample_bus.row_end <= 1'b0;
		end else begin
			if (sample_bus.valid && sample_bus.ready) begin
				absorb_sample(sample_bus.prob, sample_bus.row_end);
				items_accepted++;
			end
			if (!sample_bus.valid || sample_bus.ready) begin
				if (sample_queue.size() != 0 && !sender_hold &&
						$urandom_range(99) >= tx_idle_pct) begin
					next_sample = sample_queue.pop_front();
					sample_bus.valid   <= 1'b1;
					sample_bus.prob    <= next_sample.prob;
					sample_bus.row_end <= next_sample.is_end;
				end else begin
					sample_bus.valid <= 1'b0;
				end
			end
		end
	end

	// result monitor: check the accepted transaction, then pick the next ready
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_bus.ready <= 1'b0;
		end else begin
			if (result_bus.valid && result_bus.ready)
				check_result();
			result_bus.ready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
		end
	end

	// long receiver hold-off, counted here so the sender keeps pushing meanwhile
	initial begin : rx_holdoff
		rx_hold = 1'b0;
		wait (holdoff_go);
		@(posedge clk);
		rx_hold <= 1'b1;
		repeat (HOLDOFF_CYCLES) @(posedge clk);
		rx_hold <= 1'b0;
	end

	initial begin : run_limit
		#(RUN_LIMIT_NS);
		$display("[%0t] timeout: run did not finish", $realtime);
		$display("*** FAILED ***");
		$finish;
	end

	task automatic push_sample(int v, logic is_end);
		sample_item_t it;
		it.prob   = prob_t'(v);
		it.is_end = is_end;
		sample_queue.push_back(it);
		items_queued++;
	endtask

	// row of n samples: head first, the rest all equal to fill
	task automatic queue_flat_row(int n, int fill, int head);
		for (int k = 0; k < n; k++)
			push_sample((k == 0) ? head : fill, k == n - 1);
	endtask

	// row that sums to one, then skewed on its largest element; spoil 1 replaces one
	// element with a negative value, spoil 2 with a value above one
	task automatic queue_good_row(int n, int skew, int spoil);
		int vals[MAX_GEN_ROW];
		int left;
		int j;
		int t;
		int big;
		left = ONE_PROB;
		for (int k = 0; k < n - 1; k++) begin
			vals[k] = $urandom_range(left, 0);
			left -= vals[k];
		end
		vals[n-1] = left;
		for (int k = n - 1; k > 0; k--) begin
			j       = $urandom_range(k, 0);
			t       = vals[k];
			vals[k] = vals[j];
			vals[j] = t;
		end
		big = 0;
		for (int k = 1; k < n; k++)
			if (vals[k] > vals[big])
				big = k;
		vals[big] += skew;
		if (vals[big] < 0)
			vals[big] = 0;
		if (vals[big] > 131071)
			vals[big] = 131071;
		j = $urandom_range(n - 1, 0);
		if (spoil == 1)
			vals[j] = -int'($urandom_range(131072, 1));
		else if (spoil == 2)
			vals[j] = $urandom_range(131071, ONE_PROB + 1);
		for (int k = 0; k < n; k++)
			push_sample(vals[k], k == n - 1);
	endtask

	// mostly well-formed rows, some skewed to the tolerance edge, plus spoiled rows and noise
	task automatic queue_random_row();
		int kind;
		int n;
		int skew;
		int tol;
		int v;
		bit is_end;
		kind = $urandom_range(99);
		n    = ($urandom_range(9) == 0) ? $urandom_range(MAX_GEN_ROW, 9) : $urandom_range(8, 1);
		tol  = int'(cfg_tol);
		case ($urandom_range(3))
			0, 1: skew = 0;
			2:    skew = tol + $urandom_range(2) - 1;
			default: skew = $urandom_range(2 * tol + 10);
		endcase
		if ($urandom_range(1))
			skew = -skew;
		if (kind < 70) begin
			queue_good_row(n, skew, 0);
		end else if (kind < 80) begin
			queue_good_row(n, skew, 1);
		end else if (kind < 88) begin
			queue_good_row(n, skew, 2);
		end else begin
			do begin
				v      = int'(prob_t'($urandom()));
				is_end = ($urandom_range(3) == 0);
				push_sample(v, is_end);
			end while (!is_end);
		end
	endtask

	// wait until every sample is taken and every result checked, then settle
	task automatic wait_drained();
		while (items_accepted != items_queued || expected_rows.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, int unsigned data);
		@(posedge clk);
		cfg_bus.valid     <= 1'b1;
		cfg_bus.reg_index <= idx;
		cfg_bus.wdata     <= data[CFG_DATA_W-1:0];
		do @(posedge clk); while (cfg_bus.ready !== 1'b1);
		case (idx)
			CFG_MEASURE_MODE: cfg_mode = data[MODE_W-1:0];
			CFG_REJECT_THR:   cfg_thr  = data[OUT_W-1:0];
			CFG_SUM_TOL:      cfg_tol  = data[TOL_W-1:0];
			default: ;
		endcase
		cfg_bus.valid <= 1'b0;
	endtask

	// drain, reprogram all registers, set idling, queue a batch of random rows
	task automatic run_phase(mode_t m, int unsigned thr, int unsigned tol, int tx, int rx);
		int start;
		wait_drained();
		write_reg(CFG_MEASURE_MODE, m);
		write_reg(CFG_REJECT_THR, thr);
		write_reg(CFG_SUM_TOL, tol);
		settings_used++;
		@(negedge clk);
		tx_idle_pct  = tx;
		rx_stall_pct = rx;
		start = items_queued;
		while (items_queued - start < PHASE_ITEMS)
			queue_random_row();
	endtask

	initial begin : main_seq
		int pause_mark;
		arst_n               = 1'b0;
		sample_bus.valid     = 1'b0;
		sample_bus.prob      = '0;
		sample_bus.row_end   = 1'b0;
		result_bus.ready     = 1'b0;
		cfg_bus.valid        = 1'b0;
		cfg_bus.reg_index    = CFG_MEASURE_MODE;
		cfg_bus.wdata        = '0;
		cfg_mode             = MODE_ENTROPY;
		cfg_thr              = '0;
		cfg_tol              = SUM_TOL_RESET;
		tx_idle_pct          = 0;
		rx_stall_pct         = 0;
		sender_hold          = 1'b0;
		holdoff_go           = 1'b0;
		items_queued         = 0;
		items_accepted       = 0;
		rows_checked         = 0;
		error_count          = 0;
		settings_used        = 1;
		clear_row_state();

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed rows under the reset register values
		queue_flat_row(1, 0, ONE_PROB);
		queue_flat_row(2, 32768, 32768);
		queue_flat_row(3, 0, ONE_PROB);
		queue_flat_row(4, 16384, 16384);
		queue_flat_row(2, 65535, 1);
		queue_flat_row(1, 0, 131071);
		queue_flat_row(2, ONE_PROB, -131072);
		queue_flat_row(1, 0, ONE_PROB + 66);
		queue_flat_row(1, 0, ONE_PROB - 67);
		wait_drained();
		write_reg(CFG_MEASURE_MODE, MODE_MARGIN);
		settings_used++;
		queue_flat_row(1, 0, ONE_PROB);
		queue_flat_row(2, 32768, 32768);
		queue_flat_row(2, 16384, 49152);
		wait_drained();
		write_reg(CFG_MEASURE_MODE, MODE_MAXCONF);
		settings_used++;
		queue_flat_row(1, 0, ONE_PROB);
		wait_drained();
		write_reg(CFG_MEASURE_MODE, MODE_UNUSED);
		settings_used++;
		queue_flat_row(2, ONE_PROB, 0);

		// no idling; long hold-off on results, then a row past the length limit
		run_phase(MODE_ENTROPY, $urandom_range(3 << 16, 0), SUM_TOL_RESET, 0, 0);
		holdoff_go = 1'b1;
		queue_flat_row(MAX_CLASSES + 1, 0, ONE_PROB);

		// sender idling; halfway through, pause until all results are back
		run_phase(MODE_MARGIN, 0, 0, 50, 0);
		pause_mark = items_queued - PHASE_ITEMS / 2;
		while (items_accepted < pause_mark)
			@(negedge clk);
		sender_hold = 1'b1;
		while (expected_rows.size() != 0)
			@(negedge clk);
		sender_hold = 1'b0;

		// widest tolerance: an all-zero row passes and gives a zero maximum
		run_phase(MODE_MAXCONF, 1 << 19, ONE_PROB, 0, 50);
		queue_flat_row(1, 0, 0);

		run_phase(MODE_UNUSED, $urandom_range(ONE_PROB, 0), $urandom_range(200, 0), 35, 35);
		run_phase(MODE_ENTROPY, $urandom_range(3 << 16, 0), $urandom_range(200, 0), 0, 0);
		run_phase(MODE_MARGIN, $urandom_range(ONE_PROB, 0), $urandom_range(200, 0), 50, 0);
		run_phase(MODE_MAXCONF, $urandom_range(ONE_PROB, 0), SUM_TOL_RESET, 0, 50);
		run_phase(MODE_ENTROPY, $urandom_range(3 << 16, 0), $urandom_range(200, 0), 35, 35);
		wait_drained();

		$display("Run covered %0d samples and %0d row results under %0d register settings",
			items_accepted, rows_checked, settings_used);
		$display("Modes: entropy, margin, max confidence, unused code; %0d mismatches",
			error_count);
		if (error_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

>>> files.f
rtl/cum_pkg.sv
rtl/cum_if.sv
rtl/classifier_uncertainty_measure.sv
rtl/cum_checker.sv
test/testbench.sv
